/* hdl/odd_even_transposition_sorter_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the odd-even transposition sorter
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ODD_EVEN_TRANSPOSITION_SORTER_CORE_MACROS_SVH
`define ODD_EVEN_TRANSPOSITION_SORTER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define OETS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define OETS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define OETS_ASSERT_IMPLY(label, ante, cons, msg)
`define OETS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* hdl/oets_pkg.sv */
// ----------------------------------------------------------------------------
// oets_pkg
// Shared data type and widths for the odd-even transposition sorter.
// ----------------------------------------------------------------------------
package oets_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

endpackage

/* hdl/oets_mem.sv */
// ----------------------------------------------------------------------------
// oets_mem
// Element store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module oets_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  oets_pkg::data_t       wdata,
    input  logic [AW-1:0]         raddr_a,
    input  logic [AW-1:0]         raddr_b,
    output oets_pkg::data_t       rdata_a,
    output oets_pkg::data_t       rdata_b
);
    import oets_pkg::*;

    data_t mem [DEPTH];
    data_t rdata_a_reg;
    data_t rdata_b_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge clk)
    begin
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* hdl/oets_cmpx.sv */
// ----------------------------------------------------------------------------
// oets_cmpx
// Shared compare-exchange unit: registers the smaller and larger of a pair.
// ----------------------------------------------------------------------------
module oets_cmpx (
    input  logic            clk,
    input  logic            en,
    input  oets_pkg::data_t a,
    input  oets_pkg::data_t b,
    output oets_pkg::data_t lo,
    output oets_pkg::data_t hi
);
    import oets_pkg::*;

    data_t lo_reg;
    data_t hi_reg;
    logic  swap;

    // Signed compare of the pair
    assign swap = (a > b);

    // Capture ordered pair
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= swap ? b : a;
            hi_reg <= swap ? a : b;
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

/* hdl/odd_even_transposition_sorter_core.sv */
// ----------------------------------------------------------------------------
// odd_even_transposition_sorter_core
// Batch sorter: loads signed values, sorts them by odd-even transposition
// with one compare-exchange unit, then streams them out in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*) takes one value per request, s_tlast closes a batch.
//   Master channel (m_*) returns the batch in ascending order, m_tlast on the
//   largest value, m_tuser set on every result of a batch longer than the
//   store (values after the first MAX_ITEMS are dropped).
//   Loading: one value per cycle, s_tready high while the core is loading.
//   Sorting a batch of N values: N phases, each with P pairs, where P is N/2
//   or (N-1)/2 rounded down; the pairs are worked one at a time by the
//   single compare-exchange unit and the one write port of the element
//   store: each pair is selected, read, compared, then written back, the
//   smaller value before the larger.
//   Emitting: each result is read from the store, then loaded into the output
//   register when that register is empty or its result is being taken.
//   s_tready is low from the closing request until the last result is loaded
//   into the output register. A stalled receiver holds the output register
//   and pauses emission; loading of the next batch may start while the last
//   result still waits.
//   Reset empties the batch and the output register; the store is not cleared
//   and needs no clearing pass, since every entry read was written first.
// ----------------------------------------------------------------------------
`include "odd_even_transposition_sorter_core_macros.svh"

module odd_even_transposition_sorter_core #(
    parameter int MAX_ITEMS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,   // end_of_batch
    output logic        m_tuser    // [0] overflow
);
    import oets_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 2);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT_NEXT,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SORT_WR_LO,
        ST_SORT_WR_HI,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    state_t          state_reg,   state_next;
    logic [CW-1:0]   count_reg,   count_next;
    logic [CW-1:0]   phase_reg,   phase_next;
    logic [CW-1:0]   pair_reg,    pair_next;
    logic [CW-1:0]   emit_idx_reg, emit_idx_next;
    logic            dropped_reg, dropped_next;
    logic            m_tvalid_reg, m_tvalid_next;
    data_t           m_data_reg;
    logic            m_last_reg;
    logic            m_user_reg;

    logic            in_req;
    logic            out_free;
    logic            out_load;
    logic            emit_last;
    logic [CW-1:0]   pair_hi;
    logic            store_full;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    data_t           mem_wdata;
    logic [AW-1:0]   mem_raddr_a;
    logic [AW-1:0]   mem_raddr_b;
    data_t           rdata_a;
    data_t           rdata_b;
    data_t           cmp_lo;
    data_t           cmp_hi;

    assign in_req     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign out_load   = (state_reg == ST_EMIT_LD) && out_free;
    assign emit_last  = (emit_idx_reg + CW'(1)) == count_reg;
    assign pair_hi    = pair_reg + CW'(1);
    assign store_full = (count_reg == CW'(MAX_ITEMS));

    // Element store
    oets_mem #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Shared compare-exchange unit
    oets_cmpx u_cmpx (
        .clk (clk),
        .en  (state_reg == ST_SORT_CMP),
        .a   (rdata_a),
        .b   (rdata_b),
        .lo  (cmp_lo),
        .hi  (cmp_hi)
    );

    // Select store addresses and write source
    always_comb
    begin
        mem_raddr_a = (state_reg == ST_EMIT_RD || state_reg == ST_EMIT_LD)
                    ? emit_idx_reg[AW-1:0] : pair_reg[AW-1:0];
        mem_raddr_b = pair_hi[AW-1:0];
        mem_we      = 1'b0;
        mem_waddr   = count_reg[AW-1:0];
        mem_wdata   = s_tdata;
        case (state_reg)
            ST_LOAD:
            begin
                mem_we = in_req && !store_full;
            end
            ST_SORT_WR_LO:
            begin
                mem_we    = 1'b1;
                mem_waddr = pair_reg[AW-1:0];
                mem_wdata = cmp_lo;
            end
            ST_SORT_WR_HI:
            begin
                mem_we    = 1'b1;
                mem_waddr = pair_hi[AW-1:0];
                mem_wdata = cmp_hi;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        phase_next    = phase_reg;
        pair_next     = pair_reg;
        emit_idx_next = emit_idx_reg;
        dropped_next  = dropped_reg;
        m_tvalid_next = m_tvalid_reg;

        // Drop the output request once taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (in_req)
                begin
                    if (store_full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    if (s_tlast)
                    begin
                        phase_next = '0;
                        pair_next  = '0;
                        state_next = ST_SORT_NEXT;
                    end
                end
            end
            ST_SORT_NEXT:
            begin
                if (phase_reg == count_reg)
                begin
                    emit_idx_next = '0;
                    state_next    = ST_EMIT_RD;
                end
                else if (pair_hi < count_reg)
                begin
                    state_next = ST_SORT_RD;
                end
                else
                begin
                    phase_next = phase_reg + CW'(1);
                    pair_next  = phase_reg[0] ? '0 : CW'(1);
                end
            end
            ST_SORT_RD:
            begin
                state_next = ST_SORT_CMP;
            end
            ST_SORT_CMP:
            begin
                state_next = ST_SORT_WR_LO;
            end
            ST_SORT_WR_LO:
            begin
                state_next = ST_SORT_WR_HI;
            end
            ST_SORT_WR_HI:
            begin
                pair_next  = pair_reg + CW'(2);
                state_next = ST_SORT_NEXT;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    emit_idx_next = emit_idx_reg + CW'(1);
                    if (emit_last)
                    begin
                        count_next   = '0;
                        phase_next   = '0;
                        pair_next    = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            phase_reg    <= '0;
            pair_reg     <= '0;
            emit_idx_reg <= '0;
            dropped_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            phase_reg    <= phase_next;
            pair_reg     <= pair_next;
            emit_idx_reg <= emit_idx_next;
            dropped_reg  <= dropped_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Load the output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= rdata_a;
            m_last_reg <= emit_last;
            m_user_reg <= dropped_reg;
        end
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // Checks
    `OETS_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CW'(MAX_ITEMS), "count beyond store")
    `OETS_ASSERT_IMPLY(a_pair_in_range, state_reg == ST_SORT_RD,
                       pair_hi < count_reg, "pair outside batch")
    `OETS_ASSERT_IMPLY(a_emit_in_range, state_reg == ST_EMIT_RD || state_reg == ST_EMIT_LD,
                       emit_idx_reg < count_reg, "emit index outside batch")
    `OETS_ASSERT_IMPLY(a_sort_nonempty, state_reg == ST_SORT_NEXT,
                       count_reg != '0, "sorting an empty batch")
    `OETS_ASSERT_NEXT(a_close_starts_sort, s_tvalid && s_tready && s_tlast,
                      state_reg == ST_SORT_NEXT, "closing request did not start sort")

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the odd-even transposition sorter core. A short
// table of directed batches is run first: single values at the extremes
// right after reset, then small batches with duplicates and ordered and
// reversed runs. Random batches follow, including full and over-long batches.
// The table gives the results of the single values, a behavioural sorter the
// rest. Each is checked field by field as it leaves; both sides stall at random.
// ----------------------------------------------------------------------------
module tb;
    import oets_pkg::*;

    localparam int MAX_ITEMS    = 64;
    localparam int CLK_HALF     = 4;
    localparam int ITEM_TARGET  = 460;
    localparam int QUIET_AFTER  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        data_t value;
        logic  end_flag;
        logic  ovf;
    } sorted_item_t;

    typedef struct {
        data_t        value;
        logic         is_last;
        logic         typed;
        sorted_item_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] value
    logic        s_tlast;    // last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;    // [31:0] sorted_value
    logic        m_tlast;    // end_of_batch
    logic        m_tuser;    // [0] overflow

    // Batch being loaded, as the predictor sees it
    data_t        batch_values[$];
    logic         batch_dropped = 1'b0;
    // Sorted results still owed by the core, oldest first
    sorted_item_t sorted_expect[$];
    stim_row_t    directed_rows[$];

    int   error_count = 0;
    int   sent_count  = 0;
    int   cycle_count = 0;
    int   stall_left  = 0;
    logic quiet;

    assign quiet = (sent_count >= QUIET_AFTER);

    odd_even_transposition_sorter_core #(
        .MAX_ITEMS (MAX_ITEMS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF clk = ~clk;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input data_t got, input data_t want);
        $display("mismatch: %s got %h want %h", what, got, want);
        error_count++;
    endtask

    // Add one value to the batch; on the closing request sort and emit it
    task automatic predict_request(input data_t v, input logic is_last, input logic publish);
        data_t        tmp;
        sorted_item_t item;
        int           n;
        if (batch_values.size() < MAX_ITEMS)
            batch_values.push_back(v);
        else
            batch_dropped = 1'b1;
        if (is_last)
        begin
            n = batch_values.size();
            // Even phases pair (0,1),(2,3)..; odd phases pair (1,2),(3,4)..
            for (int ph = 0; ph < n; ph++)
            begin
                for (int j = 1 + (ph % 2); j < n; j += 2)
                begin
                    if (batch_values[j-1] > batch_values[j])
                    begin
                        tmp               = batch_values[j-1];
                        batch_values[j-1] = batch_values[j];
                        batch_values[j]   = tmp;
                    end
                end
            end
            for (int k = 0; k < n; k++)
            begin
                item.value    = batch_values[k];
                item.end_flag = (k == n - 1);
                item.ovf      = batch_dropped;
                if (publish)
                    sorted_expect.push_back(item);
            end
            batch_values.delete();
            batch_dropped = 1'b0;
        end
    endtask

    // Offer one request, with an optional idle burst first, and hold until taken
    task automatic send_request(input data_t v, input logic is_last, input logic publish);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= is_last;
        do @(posedge clk); while (!s_tready);
        predict_request(v, is_last, publish);
        sent_count++;
    endtask

    task automatic put_row(input data_t v, input logic is_last, input logic typed,
                           input data_t want_value);
        stim_row_t row;
        row.value         = v;
        row.is_last       = is_last;
        row.typed         = typed;
        row.want.value    = want_value;
        row.want.end_flag = 1'b1;
        row.want.ovf      = 1'b0;
        directed_rows.push_back(row);
    endtask

    // Full-range values half the time, with extremes and a narrow band for duplicates
    function automatic data_t rand_value();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return data_t'($urandom_range(0, 15)) - 8;
            default: return data_t'($urandom);
        endcase
    endfunction

    // Mostly short batches, some long ones, a few past the store
    function automatic int pick_batch_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 8);
        else if (roll < 90)
            return $urandom_range(9, 32);
        else if (roll < 96)
            return $urandom_range(33, MAX_ITEMS);
        else
            return $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
    endfunction

    // Stimulus and end of run
    initial
    begin
        int blen;
        int batch_idx;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;

        // Single values at the extremes, at zero and at minus one, straight after reset
        put_row(32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF);
        put_row(32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000);
        put_row(32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000);
        put_row(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        // Reversed pair across zero
        put_row(32'h0000_0005, 1'b0, 1'b0, '0);
        put_row(32'hFFFF_FFFB, 1'b1, 1'b0, '0);
        // Even batch mixing extremes and repeats
        put_row(32'h7FFF_FFFF, 1'b0, 1'b0, '0);
        put_row(32'h8000_0000, 1'b0, 1'b0, '0);
        put_row(32'h0000_0000, 1'b0, 1'b0, '0);
        put_row(32'hFFFF_FFFF, 1'b0, 1'b0, '0);
        put_row(32'h0000_0001, 1'b0, 1'b0, '0);
        put_row(32'h8000_0000, 1'b0, 1'b0, '0);
        put_row(32'h7FFF_FFFF, 1'b0, 1'b0, '0);
        put_row(32'h0000_0000, 1'b1, 1'b0, '0);
        // All equal
        put_row(32'h0000_0003, 1'b0, 1'b0, '0);
        put_row(32'h0000_0003, 1'b0, 1'b0, '0);
        put_row(32'h0000_0003, 1'b1, 1'b0, '0);
        // Already ascending, odd length
        put_row(32'hFFFF_FFFE, 1'b0, 1'b0, '0);
        put_row(32'hFFFF_FFFF, 1'b0, 1'b0, '0);
        put_row(32'h0000_0000, 1'b0, 1'b0, '0);
        put_row(32'h0000_0001, 1'b0, 1'b0, '0);
        put_row(32'h0000_0002, 1'b1, 1'b0, '0);
        // Descending near the extremes
        put_row(32'h7FFF_FFFE, 1'b0, 1'b0, '0);
        put_row(32'h0000_0000, 1'b0, 1'b0, '0);
        put_row(32'h8000_0001, 1'b1, 1'b0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[r])
        begin
            send_request(directed_rows[r].value, directed_rows[r].is_last,
                         !directed_rows[r].typed);
            if (directed_rows[r].typed)
                sorted_expect.push_back(directed_rows[r].want);
        end

        // Random batches: a full store and an over-long one first
        batch_idx = 0;
        while (sent_count < ITEM_TARGET)
        begin
            if (batch_idx == 0)
                blen = MAX_ITEMS;
            else if (batch_idx == 1)
                blen = MAX_ITEMS + 2;
            else
                blen = pick_batch_len();
            for (int k = 0; k < blen; k++)
                send_request(rand_value(), k == blen - 1, 1'b1);
            batch_idx++;
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding results, then watch for strays
        while (sorted_expect.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Check each result taken and steer the receiver's stalls
    always @(posedge clk)
    begin
        sorted_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sorted_expect.size() == 0)
            begin
                report_mismatch("result with nothing pending", data_t'(m_tdata), '0);
            end
            else
            begin
                want = sorted_expect.pop_front();
                if (data_t'(m_tdata) != want.value)
                    report_mismatch("sorted_value", data_t'(m_tdata), want.value);
                if (m_tlast != want.end_flag)
                    report_mismatch("end_of_batch", data_t'(m_tlast), data_t'(want.end_flag));
                if (m_tuser != want.ovf)
                    report_mismatch("overflow", data_t'(m_tuser), data_t'(want.ovf));
            end
        end

        if (quiet)
        begin
            stall_left = 0;
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/oets_pkg.sv
hdl/oets_mem.sv
hdl/oets_cmpx.sv
hdl/odd_even_transposition_sorter_core.sv
tb/tb.sv
